@@ src/qdp_pkg.sv @@
// shared types and constants for the quadrature decoder with period measurement
package qdp_pkg;

  // default parameter values
  localparam int unsigned PeriodLimitDef   = 16384;
  localparam int unsigned PositionWidthDef = 32;

  // result field widths
  localparam int unsigned PositionW    = 32;
  localparam int unsigned ErrorCountW  = 16;
  localparam int unsigned PeriodW      = 15;
  localparam int unsigned SignedPeriodW = 16;

  // one result item
  typedef struct packed {
    logic signed [PositionW-1:0]     position;
    logic [ErrorCountW-1:0]          error_count;
    logic [PeriodW-1:0]              period;
    logic signed [SignedPeriodW-1:0] signed_period;
    logic                            forward;
    logic                            stopped;
  } res_t;

endpackage

@@ src/quadrature_decoder_period_top.sv @@
// quadrature decoder with edge period measurement, top level
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | chan_a_i, chan_b_i
//  out     | output    | out_valid_o / out_stall_i| position_o, error_count_o, period_o,
//          |           |                        | signed_period_o, forward_o, stopped_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (swap channels)
//
// one request per cycle while in_stall_o is low
// decoder state updates in the accepting cycle, result lands in the output register
// a request taken during an output stall waits in a skid register; in_stall_o is high
// while it is full, so intake stays blocked until the output register can take it again
// reset clears position, error count and idle count, sets the direction to forward and the period to the limit,
// and the first request after reset or a config write only captures the channel levels
module quadrature_decoder_period_top #(
  parameter int unsigned PERIOD_LIMIT   = qdp_pkg::PeriodLimitDef,
  parameter int unsigned POSITION_WIDTH = qdp_pkg::PositionWidthDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // configuration
  input  logic                                      cfg_we_i,
  input  logic                                      cfg_wdata_i,
  // input channel
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      chan_a_i,
  input  logic                                      chan_b_i,
  // output channel
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic signed [qdp_pkg::PositionW-1:0]      position_o,
  output logic [qdp_pkg::ErrorCountW-1:0]           error_count_o,
  output logic [qdp_pkg::PeriodW-1:0]               period_o,
  output logic signed [qdp_pkg::SignedPeriodW-1:0]  signed_period_o,
  output logic                                      forward_o,
  output logic                                      stopped_o
);
  import qdp_pkg::*;

  localparam int unsigned CntW = $clog2(PERIOD_LIMIT + 1);
  localparam logic [CntW-1:0] Limit = CntW'(PERIOD_LIMIT);

  // decoder state
  logic                      swap_q;
  logic                      primed_q, primed_d;
  logic                      prev_a_q, prev_a_d;
  logic                      prev_b_q, prev_b_d;
  logic [POSITION_WIDTH-1:0] step_q, step_d;
  logic [ErrorCountW-1:0]    err_q, err_d;
  logic [CntW-1:0]           edge_q, edge_d;
  logic [CntW-1:0]           idle_q, idle_d;
  logic                      fwd_q, fwd_d;

  // output stage
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  res_t res;

  logic in_fire, out_ready;
  logic a, b, ch_a, ch_b, up;
  logic [CntW-1:0] idle_inc, edge_run;
  logic [POSITION_WIDTH+PositionW-1:0] pos_ext;
  logic [CntW+SignedPeriodW-1:0]       per_ext;
  logic [SignedPeriodW-1:0]            per16;

  function automatic logic cfg_swap_sel(input logic sw, input logic own, input logic other);
    return sw ? other : own;
  endfunction

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_ready  = !out_valid_q || !out_stall_i;

  // channel swap and change detection
  assign a    = cfg_swap_sel(swap_q, chan_a_i, chan_b_i);
  assign b    = cfg_swap_sel(swap_q, chan_b_i, chan_a_i);
  assign ch_a = a != prev_a_q;
  assign ch_b = b != prev_b_q;
  assign up   = ch_a ? (a == prev_b_q) : (b != prev_a_q);

  // idle counter stretch
  always_comb begin
    idle_inc = idle_q;
    edge_run = edge_q;
    if (idle_q < Limit) begin
      idle_inc = idle_q + 1'b1;
      if (edge_q < idle_inc) begin
        edge_run = idle_inc;
      end
    end
  end

  // next decoder state
  always_comb begin
    primed_d = primed_q;
    prev_a_d = prev_a_q;
    prev_b_d = prev_b_q;
    step_d   = step_q;
    err_d    = err_q;
    edge_d   = edge_q;
    idle_d   = idle_q;
    fwd_d    = fwd_q;
    if (!primed_q) begin
      primed_d = 1'b1;
      prev_a_d = a;
      prev_b_d = b;
    end else begin
      prev_a_d = a;
      prev_b_d = b;
      idle_d   = idle_inc;
      edge_d   = edge_run;
      if (ch_a || ch_b) begin
        edge_d = idle_inc;
        idle_d = '0;
      end
      unique case ({ch_a, ch_b})
        2'b11: begin
          fwd_d = prev_a_q == prev_b_q;
          err_d = err_q + 1'b1;
        end
        2'b10, 2'b01: begin
          fwd_d  = up;
          step_d = up ? step_q + 1'b1 : step_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // result fields from the updated state
  always_comb begin
    pos_ext             = {{PositionW{1'b0}}, step_d};
    per_ext             = {{SignedPeriodW{1'b0}}, edge_d};
    per16               = per_ext[SignedPeriodW-1:0];
    res.position        = pos_ext[PositionW-1:0];
    res.error_count     = err_d;
    res.period          = per_ext[PeriodW-1:0];
    res.signed_period   = fwd_d ? per16 : SignedPeriodW'(-per16);
    res.forward         = fwd_d;
    res.stopped         = edge_d == Limit;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q   <= 1'b0;
      primed_q <= 1'b0;
      prev_a_q <= 1'b0;
      prev_b_q <= 1'b0;
      step_q   <= '0;
      err_q    <= '0;
      edge_q   <= Limit;
      idle_q   <= '0;
      fwd_q    <= 1'b1;
    end else if (cfg_we_i) begin
      swap_q   <= cfg_wdata_i;
      primed_q <= 1'b0;
    end else if (in_fire) begin
      primed_q <= primed_d;
      prev_a_q <= prev_a_d;
      prev_b_q <= prev_b_d;
      step_q   <= step_d;
      err_q    <= err_d;
      edge_q   <= edge_d;
      idle_q   <= idle_d;
      fwd_q    <= fwd_d;
    end
  end

  // output and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      if (out_ready) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (out_ready) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_ready && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign position_o      = out_q.position;
  assign error_count_o   = out_q.error_count;
  assign period_o        = out_q.period;
  assign signed_period_o = out_q.signed_period;
  assign forward_o       = out_q.forward;
  assign stopped_o       = out_q.stopped;

  // skid register only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // a config write forces the next request to be a capture
  a_cfg_unprimes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !primed_q)
    else $error("decoder still primed after config write");

  // period and idle counters never pass the limit
  a_counters_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_q <= Limit) && (idle_q <= Limit))
    else $error("period counter beyond limit");

  // a double change counts one error and leaves the position alone
  a_double_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i && primed_q && ch_a && ch_b) |=>
      (err_q == $past(err_q) + 1'b1) && (step_q == $past(step_q)))
    else $error("double change handled wrongly");

endmodule

@@ sim/quadrature_decoder_period_top_tb.sv @@
// self-checking testbench for the quadrature decoder with period measurement
module quadrature_decoder_period_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qdp_pkg::*;

  localparam int unsigned PeriodLimit = PeriodLimitDef;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomTicks = 480;

  // readings that can be typed in by hand
  localparam res_t AtReset  = '{32'sd0, 16'd0, 15'd16384, 16'sh4000, 1'b1, 1'b1};
  localparam res_t NoReading = '0;

  // one row of the directed script
  typedef struct packed {
    logic        reconfig;
    logic        swap;
    logic        chan_a;
    logic        chan_b;
    logic [15:0] reps;
    logic        typed;
    res_t        want;
  } tick_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic chan_a_i = 1'b0;
  logic chan_b_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [PositionW-1:0]     position_o;
  logic [ErrorCountW-1:0]          error_count_o;
  logic [PeriodW-1:0]              period_o;
  logic signed [SignedPeriodW-1:0] signed_period_o;
  logic forward_o;
  logic stopped_o;

  quadrature_decoder_period_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .chan_a_i       (chan_a_i),
    .chan_b_i       (chan_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .error_count_o  (error_count_o),
    .period_o       (period_o),
    .signed_period_o(signed_period_o),
    .forward_o      (forward_o),
    .stopped_o      (stopped_o)
  );

  // directed script: forward and backward steps, a pass below zero, double changes,
  // a long hold that stretches the period, the edge that ends it, swapped channels
  tick_row_t script [26] = '{
    '{1'b1, 1'b0, 1'b0, 1'b0, 16'd1,     1'b1, AtReset},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'd40,    1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b0, 16'd2,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b1, 1'b1, 1'b0, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b1, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'd1,     1'b0, NoReading},
    '{1'b0, 1'b0, 1'b1, 1'b1, 16'd1,     1'b0, NoReading}
  };

  // idle plan per random phase, in percent
  int gap_plan [3]   = '{11, 73, 0};
  int stall_plan [3] = '{73, 11, 0};
  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int unsigned cycle_count = 0;

  res_t readings_due [$];

  // tracked decoder state
  logic        trk_swap = 1'b0;
  logic        trk_primed = 1'b0;
  logic        trk_prev_a = 1'b0;
  logic        trk_prev_b = 1'b0;
  logic [31:0] trk_position = '0;
  logic [15:0] trk_errors = '0;
  logic [31:0] trk_edge_period = PeriodLimit;
  logic [31:0] trk_idle = '0;
  logic        trk_forward = 1'b1;

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // advance the tracked state by one sample tick and return the reading it gives
  function automatic res_t decode_tick(input logic raw_a, input logic raw_b);
    logic a, b, moved_a, moved_b;
    logic [15:0] span;
    res_t r;
    a = trk_swap ? raw_b : raw_a;
    b = trk_swap ? raw_a : raw_b;
    if (!trk_primed) begin
      trk_primed = 1'b1;
    end else begin
      // idle count saturates at the limit and stretches the period
      if (trk_idle < PeriodLimit) begin
        trk_idle++;
        if (trk_edge_period < trk_idle) trk_edge_period = trk_idle;
      end
      moved_a = a != trk_prev_a;
      moved_b = b != trk_prev_b;
      if (moved_a) begin
        trk_forward = a == trk_prev_b;
        trk_position = trk_forward ? trk_position + 1 : trk_position - 1;
      end
      if (moved_b) begin
        trk_forward = b != trk_prev_a;
        trk_position = trk_forward ? trk_position + 1 : trk_position - 1;
      end
      if (moved_a || moved_b) begin
        trk_edge_period = trk_idle;
        trk_idle = '0;
      end
      if (moved_a && moved_b) trk_errors++;
    end
    trk_prev_a = a;
    trk_prev_b = b;
    span = trk_edge_period[15:0];
    r.position      = trk_position;
    r.error_count   = trk_errors;
    r.period        = trk_edge_period[PeriodW-1:0];
    r.signed_period = trk_forward ? span : -span;
    r.forward       = trk_forward;
    r.stopped       = trk_edge_period == PeriodLimit;
    return r;
  endfunction

  // offer one request after a random gap, hold it through stalls
  task automatic send_tick(input logic a, input logic b, input logic typed, input res_t want);
    res_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    chan_a_i   <= a;
    chan_b_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = decode_tick(a, b);
    readings_due.push_back(typed ? want : r);
  endtask

  // stop sending and let every outstanding reading come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // write the swap register while the block is idle
  task automatic write_swap(input logic value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    trk_swap   = value;
    trk_primed = 1'b0;
  endtask

  // result side: random stall and compare against the oldest expected reading
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{position_o, error_count_o, period_o, signed_period_o, forward_o, stopped_o};
      if (readings_due.size() == 0) begin
        $error("unexpected reading: position %0d", got.position);
        errors++;
      end else begin
        want = readings_due.pop_front();
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got.position);
          errors++;
        end
        if (got.error_count !== want.error_count) begin
          $error("error_count: expected %0d, got %0d", want.error_count, got.error_count);
          errors++;
        end
        if (got.period !== want.period) begin
          $error("period: expected %0d, got %0d", want.period, got.period);
          errors++;
        end
        if (got.signed_period !== want.signed_period) begin
          $error("signed_period: expected %0d, got %0d", want.signed_period,
                 got.signed_period);
          errors++;
        end
        if (got.forward !== want.forward) begin
          $error("forward: expected %0b, got %0b", want.forward, got.forward);
          errors++;
        end
        if (got.stopped !== want.stopped) begin
          $error("stopped: expected %0b, got %0b", want.stopped, got.stopped);
          errors++;
        end
      end
    end
    out_stall_i <= $urandom_range(99) < stall_pct;
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("quadrature_decoder_period_top_tb: errors");
    $finish;
  end

  // main sequence
  initial begin
    logic [1:0] spot;
    logic back;
    logic paused;
    int pick;
    int run;
    int sent;
    spot = 2'd0;
    back = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script
    foreach (script[i]) begin
      if (script[i].reconfig) write_swap(script[i].swap);
      repeat (script[i].reps) send_tick(script[i].chan_a, script[i].chan_b, script[i].typed,
                                        script[i].want);
    end

    // random walks along the gray sequence with holds and double changes
    for (int p = 0; p < 3; p++) begin
      gap_pct   = gap_plan[p];
      stall_pct = stall_plan[p];
      write_swap(p == 2 ? 1'($urandom_range(1)) : 1'(p == 0));
      sent   = 0;
      paused = 1'b0;
      while (sent < RandomTicks) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          // both channels flip on one tick
          spot += 2'd2;
        end else if (pick < 40) begin
          // hold, now and then long enough for a slow period
          run = ($urandom_range(19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 2);
          repeat (run) begin
            send_tick(spot[1], spot[1] ^ spot[0], 1'b0, NoReading);
            sent++;
          end
        end else begin
          if ($urandom_range(9) == 0) back = ~back;
          spot += back ? 2'd3 : 2'd1;
        end
        send_tick(spot[1], spot[1] ^ spot[0], 1'b0, NoReading);
        sent++;
        // one full pause in the middle of the first phase with every reading collected
        if (p == 0 && !paused && sent >= RandomTicks / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("quadrature_decoder_period_top_tb: clean");
    end else begin
      $display("quadrature_decoder_period_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/qdp_pkg.sv
src/quadrature_decoder_period_top.sv
sim/quadrature_decoder_period_top_tb.sv
